FILE: hdl/assert_macros.svh
// Assertion macros shared by the occupancy binning RTL.
// No dependencies; the includer provides clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while rst is high.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/lpob_pkg.sv
// Types, constants and helper functions for the lidar occupancy binning block.
// No dependencies; used by lpob_xform and lidar_point_occupancy_binning.
package lpob_pkg;

  localparam int GRID_DIM   = 240;
  localparam int CELL_SHIFT = 2;

  localparam int CELLS      = GRID_DIM * GRID_DIM;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int COORD_W    = $clog2(GRID_DIM);
  localparam int FRAC_SHIFT = 22 - CELL_SHIFT;

  localparam int PROD_W = 32;
  localparam int ACC_W  = 34;
  localparam int CELL_W = ACC_W - FRAC_SHIFT;
  localparam int SQ_W   = 32;
  localparam int R2_W   = SQ_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [15:0] Z_LOW  = -16'sd332;
  localparam logic signed [15:0] Z_HIGH = 16'sd384;

  localparam logic [63:0] R2_LOW  = 64'd4 << 16;
  localparam logic [63:0] HALF_Q8 = 64'(GRID_DIM) << (7 - CELL_SHIFT);
  localparam logic [63:0] R2_HIGH = HALF_Q8 * HALF_Q8;

  localparam logic signed [ACC_W-1:0] HALF_Q22 =
    ACC_W'(64'(GRID_DIM) << (21 - CELL_SHIFT));

  localparam int HIT_W = 3;
  typedef logic [HIT_W-1:0] hits_t;
  localparam hits_t HIT_MAX = 3'd4;

  localparam logic signed [7:0] PCT_UNKNOWN = -8'sd1;

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_XX,
    CFG_ROT_XY,
    CFG_ROT_XZ,
    CFG_ROT_YX,
    CFG_ROT_YY,
    CFG_ROT_YZ,
    CFG_POSE_VALID
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] xx;
    logic [15:0] xy;
    logic [15:0] xz;
    logic [15:0] yx;
    logic [15:0] yy;
    logic [15:0] yz;
  } rot_t;

  typedef struct packed {
    logic              valid;
    op_t               op;
    logic              act;
    logic [ADDR_W-1:0] addr;
  } cell_req_t;

  function automatic logic signed [7:0] hits_to_pct(input hits_t h);
    logic signed [7:0] p;
    unique case (h)
      3'd0:    p = -8'sd1;
      3'd1:    p = 8'sd81;
      3'd2:    p = 8'sd95;
      3'd3:    p = 8'sd98;
      default: p = 8'sd99;
    endcase
    return p;
  endfunction

endpackage

FILE: hdl/lpob_xform.sv
// Point filter and pose transform pipeline: point in, cell request out.
// Depends on lpob_pkg.
module lpob_xform (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   take,
  input  logic                   opcode,
  input  logic signed [15:0]     point_x,
  input  logic signed [15:0]     point_y,
  input  logic signed [15:0]     point_z,
  input  logic [15:0]            cell_index,
  input  lpob_pkg::rot_t         rot,
  input  logic                   pose_valid,
  output lpob_pkg::cell_req_t    req
);

  logic                     s1_valid;
  lpob_pkg::op_t            s1_op;
  logic signed [15:0]       s1_x, s1_y, s1_z;
  logic [15:0]              s1_index;

  logic signed [lpob_pkg::PROD_W-1:0] p_xx, p_xy, p_xz, p_yx, p_yy, p_yz;
  logic signed [lpob_pkg::PROD_W-1:0] sq_x, sq_y;
  logic                               z_ok;

  logic                               s2_valid;
  lpob_pkg::op_t                      s2_op;
  logic [15:0]                        s2_index;
  logic                               s2_zok;
  logic signed [lpob_pkg::PROD_W-1:0] s2_pxx, s2_pxy, s2_pxz, s2_pyx, s2_pyy, s2_pyz;
  logic [lpob_pkg::SQ_W-1:0]          s2_sqx, s2_sqy;

  logic signed [lpob_pkg::ACC_W-1:0]  acc_row, acc_col;
  logic signed [lpob_pkg::CELL_W-1:0] row_cell, col_cell;
  logic [lpob_pkg::R2_W-1:0]          r2;
  logic                               r2_ok, row_ok, col_ok, keep;

  logic                          s3_valid;
  lpob_pkg::op_t                 s3_op;
  logic                          s3_keep;
  logic [15:0]                   s3_index;
  logic [lpob_pkg::COORD_W-1:0]  s3_row, s3_col;

  logic                          act3;
  logic [lpob_pkg::ADDR_W-1:0]   addr3;

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
    end
    if (adv && take) begin
      s1_op    <= lpob_pkg::op_t'(opcode);
      s1_x     <= point_x;
      s1_y     <= point_y;
      s1_z     <= point_z;
      s1_index <= cell_index;
    end
  end

  always_comb begin
    p_xx = lpob_pkg::PROD_W'($signed(rot.xx)) * lpob_pkg::PROD_W'(s1_x);
    p_xy = lpob_pkg::PROD_W'($signed(rot.xy)) * lpob_pkg::PROD_W'(s1_y);
    p_xz = lpob_pkg::PROD_W'($signed(rot.xz)) * lpob_pkg::PROD_W'(s1_z);
    p_yx = lpob_pkg::PROD_W'($signed(rot.yx)) * lpob_pkg::PROD_W'(s1_x);
    p_yy = lpob_pkg::PROD_W'($signed(rot.yy)) * lpob_pkg::PROD_W'(s1_y);
    p_yz = lpob_pkg::PROD_W'($signed(rot.yz)) * lpob_pkg::PROD_W'(s1_z);
    sq_x = lpob_pkg::PROD_W'(s1_x) * lpob_pkg::PROD_W'(s1_x);
    sq_y = lpob_pkg::PROD_W'(s1_y) * lpob_pkg::PROD_W'(s1_y);
    z_ok = (s1_z >= lpob_pkg::Z_LOW) && (s1_z <= lpob_pkg::Z_HIGH);
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
    if (adv) begin
      s2_op    <= s1_op;
      s2_index <= s1_index;
      s2_zok   <= z_ok;
      s2_pxx   <= p_xx;
      s2_pxy   <= p_xy;
      s2_pxz   <= p_xz;
      s2_pyx   <= p_yx;
      s2_pyy   <= p_yy;
      s2_pyz   <= p_yz;
      s2_sqx   <= $unsigned(sq_x);
      s2_sqy   <= $unsigned(sq_y);
    end
  end

  always_comb begin
    acc_row  = lpob_pkg::ACC_W'(s2_pxx) + lpob_pkg::ACC_W'(s2_pxy)
             + lpob_pkg::ACC_W'(s2_pxz) + lpob_pkg::HALF_Q22;
    acc_col  = lpob_pkg::ACC_W'(s2_pyx) + lpob_pkg::ACC_W'(s2_pyy)
             + lpob_pkg::ACC_W'(s2_pyz) + lpob_pkg::HALF_Q22;
    // arithmetic shift floors toward minus infinity
    row_cell = lpob_pkg::CELL_W'(acc_row >>> lpob_pkg::FRAC_SHIFT);
    col_cell = lpob_pkg::CELL_W'(acc_col >>> lpob_pkg::FRAC_SHIFT);
    row_ok   = !row_cell[lpob_pkg::CELL_W-1]
             && ($unsigned(row_cell) < lpob_pkg::CELL_W'(lpob_pkg::GRID_DIM));
    col_ok   = !col_cell[lpob_pkg::CELL_W-1]
             && ($unsigned(col_cell) < lpob_pkg::CELL_W'(lpob_pkg::GRID_DIM));
    r2       = lpob_pkg::R2_W'(s2_sqx) + lpob_pkg::R2_W'(s2_sqy);
    r2_ok    = (64'(r2) >= lpob_pkg::R2_LOW) && (64'(r2) <= lpob_pkg::R2_HIGH);
    keep     = pose_valid && s2_zok && r2_ok && row_ok && col_ok;
  end

  // stage 3: cell coordinates
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
    if (adv) begin
      s3_op    <= s2_op;
      s3_keep  <= keep;
      s3_index <= s2_index;
      s3_row   <= lpob_pkg::COORD_W'($unsigned(row_cell));
      s3_col   <= lpob_pkg::COORD_W'($unsigned(col_cell));
    end
  end

  always_comb begin
    if (s3_op == lpob_pkg::OP_READ) begin
      act3  = 32'(s3_index) < 32'(lpob_pkg::CELLS);
      addr3 = lpob_pkg::ADDR_W'(s3_index);
    end else begin
      act3  = s3_keep;
      addr3 = lpob_pkg::ADDR_W'(s3_row) * lpob_pkg::ADDR_W'(lpob_pkg::GRID_DIM)
            + lpob_pkg::ADDR_W'(s3_col);
    end
  end

  // stage 4: cell request
  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (adv) begin
      req.valid <= s3_valid;
    end
    if (adv) begin
      req.op   <= s3_op;
      req.act  <= act3;
      req.addr <= addr3;
    end
  end

endmodule

FILE: hdl/lidar_point_occupancy_binning.sv
// Top level of the lidar occupancy binning block: config registers, hit-count
// memory with clearing sweep, read-modify-write stage and result register.
// Depends on lpob_pkg, lpob_xform and assert_macros.svh.
//
//   channel   signals                                        direction
//   input     in_valid/in_ready, opcode, point_x/y/z,        in
//             cell_index
//   result    out_valid/out_ready, cell_value                out
//   config    cfg_we, cfg_index, cfg_data                    in
//
// One item per cycle while the result register drains; a read result passes
// through four pipeline stages, the memory read and the result register.
// After reset the hit memory is swept to zero, one cell per cycle, over all
// CELLS (57600) cells; in_ready stays low during the sweep, config writes are taken.
// A held result stalls the whole pipeline, memory read port included.
`include "assert_macros.svh"

module lidar_point_occupancy_binning (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic signed [15:0]                point_x,
  input  logic signed [15:0]                point_y,
  input  logic signed [15:0]                point_z,
  input  logic [15:0]                       cell_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [7:0]                 cell_value,
  input  logic                              cfg_we,
  input  logic [lpob_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lpob_pkg::CFG_DATA_W-1:0]   cfg_data
);

  lpob_pkg::rot_t       rot;
  logic                 pose_valid;
  logic                 adv;
  logic                 take;
  lpob_pkg::cell_req_t  req;

  logic                         clr_busy;
  logic [lpob_pkg::ADDR_W-1:0]  clr_addr;

  lpob_pkg::hits_t              mem [lpob_pkg::CELLS];
  lpob_pkg::hits_t              rd_data;
  logic                         v5;
  lpob_pkg::op_t                op5;
  logic                         act5;
  logic [lpob_pkg::ADDR_W-1:0]  addr5;

  logic                         fwd_valid;
  logic [lpob_pkg::ADDR_W-1:0]  fwd_addr;
  lpob_pkg::hits_t              fwd_data;

  lpob_pkg::hits_t              hits_cur;
  lpob_pkg::hits_t              hits_new;
  logic                         item_wr;
  logic                         wr_en;
  logic [lpob_pkg::ADDR_W-1:0]  wr_addr;
  lpob_pkg::hits_t              wr_data;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !clr_busy;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot.xx     <= 16'sd16384;
      rot.xy     <= '0;
      rot.xz     <= '0;
      rot.yx     <= '0;
      rot.yy     <= 16'sd16384;
      rot.yz     <= '0;
      pose_valid <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpob_pkg::CFG_ROT_XX:     rot.xx     <= cfg_data;
        lpob_pkg::CFG_ROT_XY:     rot.xy     <= cfg_data;
        lpob_pkg::CFG_ROT_XZ:     rot.xz     <= cfg_data;
        lpob_pkg::CFG_ROT_YX:     rot.yx     <= cfg_data;
        lpob_pkg::CFG_ROT_YY:     rot.yy     <= cfg_data;
        lpob_pkg::CFG_ROT_YZ:     rot.yz     <= cfg_data;
        lpob_pkg::CFG_POSE_VALID: pose_valid <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lpob_xform u_xform (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .take       (take),
    .opcode     (opcode),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .cell_index (cell_index),
    .rot        (rot),
    .pose_valid (pose_valid),
    .req        (req)
  );

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == lpob_pkg::ADDR_W'(lpob_pkg::CELLS - 1)) begin
        clr_busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + lpob_pkg::ADDR_W'(1);
      end
    end
  end

  // forward the write made at the edge this item was read
  always_comb begin
    if (fwd_valid && (fwd_addr == addr5)) begin
      hits_cur = fwd_data;
    end else begin
      hits_cur = rd_data;
    end
    if (op5 == lpob_pkg::OP_READ) begin
      hits_new = '0;
    end else if (hits_cur < lpob_pkg::HIT_MAX) begin
      hits_new = hits_cur + lpob_pkg::HIT_W'(1);
    end else begin
      hits_new = hits_cur;
    end
    item_wr = adv && v5 && act5;
    wr_en   = clr_busy || item_wr;
    wr_addr = clr_busy ? clr_addr : addr5;
    wr_data = clr_busy ? '0 : hits_new;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (adv) begin
      rd_data <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      fwd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v5        <= req.valid;
      fwd_valid <= v5 && act5;
      out_valid <= v5 && (op5 == lpob_pkg::OP_READ);
    end
    if (adv) begin
      op5        <= req.op;
      act5       <= req.act;
      addr5      <= req.addr;
      fwd_addr   <= addr5;
      fwd_data   <= hits_new;
      cell_value <= act5 ? lpob_pkg::hits_to_pct(hits_cur) : lpob_pkg::PCT_UNKNOWN;
    end
  end

  `ASSERT_CLK(a_sweep_pipe_empty, clr_busy |-> !req.valid && !v5 && !out_valid, "item in flight during clearing sweep")
  `ASSERT_CLK(a_write_saturates, wr_en |-> wr_data <= lpob_pkg::HIT_MAX, "hit count written above cap")
  `ASSERT_CLK(a_read_gives_result, (adv && v5 && op5 == lpob_pkg::OP_READ) |=> out_valid, "read item lost its result")
  `ASSERT_CLK(a_sweep_once, !clr_busy |=> !clr_busy, "clearing sweep restarted without reset")

endmodule
